// ----- rtl/rlud_pkg.sv -----
// shared types, register codes, sizes and fixed-point helpers for the
// lens undistortion remap block; no dependencies
package rlud_pkg;

  // image size for the bounds test
  localparam int IMG_WIDTH  = 752;
  localparam int IMG_HEIGHT = 480;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_K1 = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_K2 = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_P1 = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_P2 = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FX = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FY = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CX = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CY = 4'd7;

  // reset values of the registers
  localparam logic [31:0] K1_RESET = 32'hFFB7_7291;
  localparam logic [31:0] K2_RESET = 32'd1240827;
  localparam logic [31:0] P1_RESET = 32'd3248;
  localparam logic [31:0] P2_RESET = 32'd296;
  localparam logic [15:0] FX_RESET = 16'd7338;
  localparam logic [15:0] FY_RESET = 16'd7317;
  localparam logic [15:0] CX_RESET = 16'd5875;
  localparam logic [15:0] CY_RESET = 16'd3974;

  // normalizing divider: 44 quotient bits, 4 per stage
  localparam int DIV_WIDTH          = 44;
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = DIV_WIDTH / DIV_BITS_PER_STAGE;
  // abs register, iteration stages, saturation register
  localparam int DIV_LATENCY        = DIV_STAGES + 2;
  // distortion stages p1..p7, reprojection r1..r2, output register
  localparam int LATENCY            = DIV_LATENCY + 7 + 3;

  localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;

  typedef struct packed {
    logic [11:0] dst_col;
    logic [11:0] dst_row;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] src_col;
    logic signed [15:0] src_row;
    logic               in_bounds;
  } result_t;

  // saturating Q7.24 add
  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -33'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  // Q7.24 product, truncated toward zero, saturated
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] pa;
    logic signed [39:0] t;
    p  = a * b;
    pa = p + ((p < 0) ? 64'sd16777215 : 64'sd0);
    t  = 40'(pa >>> 24);
    if (t > 40'sh00_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (t < -40'sh00_8000_0000) begin
      return 32'sh8000_0000;
    end
    return t[31:0];
  endfunction

endpackage

// ----- rtl/lens_undistort_remap_top.sv -----
// lens undistortion remap top: configuration registers, distortion pipeline,
// bounds test; depends on rlud_pkg, rlud_div, rlud_reproj
//
// One destination pixel (dst_col, dst_row) is taken per cycle whenever start
// is high; busy is always low. Its source coordinate and in-bounds flag appear
// on result with done high for one cycle, after the normalizing dividers (abs
// register, 44 quotient bits at 4 bits per stage, saturation register), 7 stages of
// Q7.24 multiply and add for the radial-tangential model, 2 reprojection stages
// and the output register. The receiver cannot stall; every result must be
// taken in its cycle. Configuration writes complete at once (cfg_ready is
// always high) and must only be made while no pixel is in flight.
module lens_undistort_remap_top import rlud_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  cmd_t                   cmd,
  output logic                   done,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic signed [31:0] k1, k2, p1, p2;
  logic [15:0]        fx, fy, cx, cy;
  logic [15:0]        fx_eff, fy_eff;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k1 <= K1_RESET;
      k2 <= K2_RESET;
      p1 <= P1_RESET;
      p2 <= P2_RESET;
      fx <= FX_RESET;
      fy <= FY_RESET;
      cx <= CX_RESET;
      cy <= CY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_K1:  k1 <= cfg_data;
        REG_K2:  k2 <= cfg_data;
        REG_P1:  p1 <= cfg_data;
        REG_P2:  p2 <= cfg_data;
        REG_FX:  fx <= cfg_data[15:0];
        REG_FY:  fy <= cfg_data[15:0];
        REG_CX:  cx <= cfg_data[15:0];
        REG_CY:  cy <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // a zero focal length acts as one
  assign fx_eff = (fx == 16'd0) ? 16'd1 : fx;
  assign fy_eff = (fy == 16'd0) ? 16'd1 : fy;

  // normalization
  logic               dv, dv_y;
  logic signed [31:0] x0, y0;

  rlud_div u_div_x (
    .clk, .rst,
    .in_valid (start && !busy),
    .pix      (cmd.dst_col),
    .center   (cx),
    .focal    (fx_eff),
    .out_valid(dv),
    .q        (x0)
  );

  rlud_div u_div_y (
    .clk, .rst,
    .in_valid (start && !busy),
    .pix      (cmd.dst_row),
    .center   (cy),
    .focal    (fy_eff),
    .out_valid(dv_y),
    .q        (y0)
  );

  logic v1, v2, v3, v4, v5, v6, v7;
  logic signed [31:0] x1, y1, xx1, yy1, xy1;
  logic signed [31:0] x2, y2, r2_2, txy2, txx2, tyy2;
  logic signed [31:0] x3, y3, r4_3, k1r2_3, p1t3, p2t3, sx3, sy3;
  logic signed [31:0] x4, y4, k2r4_4, a4, p1t4, p2t4, p2s4, p1s4;
  logic signed [31:0] x5, y5, rad5, p1t5, p2t5, p2s5, p1s5;
  logic signed [31:0] xr6, yr6, p1t6, p2t6, p2s6, p1s6;
  logic signed [31:0] xd7, yd7;

  // p1: squares and cross product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= dv;
    end
    x1  <= x0;
    y1  <= y0;
    xx1 <= qmul(x0, x0);
    yy1 <= qmul(y0, y0);
    xy1 <= qmul(x0, y0);
  end

  // p2: r squared and doubled terms
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    x2   <= x1;
    y2   <= y1;
    r2_2 <= qadd(xx1, yy1);
    txy2 <= qadd(xy1, xy1);
    txx2 <= qadd(xx1, xx1);
    tyy2 <= qadd(yy1, yy1);
  end

  // p3: r4, k1 term, tangential cross terms
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    x3     <= x2;
    y3     <= y2;
    r4_3   <= qmul(r2_2, r2_2);
    k1r2_3 <= qmul(k1, r2_2);
    p1t3   <= qmul(p1, txy2);
    p2t3   <= qmul(p2, txy2);
    sx3    <= qadd(r2_2, txx2);
    sy3    <= qadd(r2_2, tyy2);
  end

  // p4: k2 term and tangential square terms
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    x4     <= x3;
    y4     <= y3;
    k2r4_4 <= qmul(k2, r4_3);
    a4     <= qadd(Q_ONE, k1r2_3);
    p1t4   <= p1t3;
    p2t4   <= p2t3;
    p2s4   <= qmul(p2, sx3);
    p1s4   <= qmul(p1, sy3);
  end

  // p5: radial factor
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    x5   <= x4;
    y5   <= y4;
    rad5 <= qadd(a4, k2r4_4);
    p1t5 <= p1t4;
    p2t5 <= p2t4;
    p2s5 <= p2s4;
    p1s5 <= p1s4;
  end

  // p6: radial scaling
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    xr6  <= qmul(x5, rad5);
    yr6  <= qmul(y5, rad5);
    p1t6 <= p1t5;
    p2t6 <= p2t5;
    p2s6 <= p2s5;
    p1s6 <= p1s5;
  end

  // p7: distorted coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    xd7 <= qadd(qadd(xr6, p1t6), p2s6);
    yd7 <= qadd(qadd(yr6, p2t6), p1s6);
  end

  // reprojection
  logic               rv, rv_y;
  logic signed [15:0] sc, sr;

  rlud_reproj u_reproj_x (
    .clk, .rst,
    .in_valid (v7),
    .d        (xd7),
    .focal    (fx_eff),
    .center   (cx),
    .out_valid(rv),
    .coord    (sc)
  );

  rlud_reproj u_reproj_y (
    .clk, .rst,
    .in_valid (v7),
    .d        (yd7),
    .focal    (fy_eff),
    .center   (cy),
    .out_valid(rv_y),
    .coord    (sr)
  );

  // output register with bounds test
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rv;
    end
    result.src_col   <= sc;
    result.src_row   <= sr;
    result.in_bounds <= !sc[15] && !sr[15] && (sc < 16'(IMG_WIDTH)) &&
                        (sr < 16'(IMG_HEIGHT));
  end

  // every accepted pixel yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted pixel");

  // no result without an accepted pixel
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without accepted pixel");

  // both axes travel in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (dv == dv_y) && (rv == rv_y))
    else $error("axis pipelines out of step");

  // an in-bounds result has non-negative coordinates
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (done && result.in_bounds) |-> (!result.src_col[15] && !result.src_row[15]))
    else $error("in-bounds flag on negative coordinate");

endmodule

// ----- rtl/rlud_div.sv -----
// pipelined normalizing divider: (pix*16 - center) * 2^24 / focal, Q7.24
// truncated toward zero and saturated; depends on rlud_pkg
module rlud_div import rlud_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [11:0]        pix,
  input  logic [15:0]        center,
  input  logic [15:0]        focal,
  output logic               out_valid,
  output logic signed [31:0] q
);

  logic                 v   [0:DIV_STAGES];
  logic                 neg [0:DIV_STAGES];
  logic [15:0]          rem [0:DIV_STAGES];
  logic [DIV_WIDTH-1:0] dvd [0:DIV_STAGES];
  logic [DIV_WIDTH-1:0] quo [0:DIV_STAGES];
  logic signed [17:0]   num;
  logic [16:0]          mag;

  // signed numerator and its magnitude
  always_comb begin
    num = $signed({2'b00, pix, 4'b0000}) - $signed({2'b00, center});
    mag = num[17] ? 17'(-num) : num[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    neg[0] <= num[17];
    rem[0] <= '0;
    dvd[0] <= {3'b000, mag, 24'd0};
    quo[0] <= '0;
  end

  // restoring division, DIV_BITS_PER_STAGE (4) quotient bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [15:0]          rem_next;
    logic [DIV_WIDTH-1:0] dvd_next;
    logic [DIV_WIDTH-1:0] quo_next;

    always_comb begin
      logic [16:0] t;
      rem_next = rem[g];
      dvd_next = dvd[g];
      quo_next = quo[g];
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
        t        = {rem_next, dvd_next[DIV_WIDTH-1]};
        dvd_next = {dvd_next[DIV_WIDTH-2:0], 1'b0};
        if (t >= {1'b0, focal}) begin
          rem_next = 16'(t - {1'b0, focal});
          quo_next = {quo_next[DIV_WIDTH-2:0], 1'b1};
        end else begin
          rem_next = t[15:0];
          quo_next = {quo_next[DIV_WIDTH-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else begin
        v[g+1] <= v[g];
      end
      neg[g+1] <= neg[g];
      rem[g+1] <= rem_next;
      dvd[g+1] <= dvd_next;
      quo[g+1] <= quo_next;
    end
  end

  // sign and saturation to Q7.24
  logic [DIV_WIDTH-1:0] qf;
  logic signed [31:0]   q_next;
  always_comb begin
    qf = quo[DIV_STAGES];
    if (!neg[DIV_STAGES]) begin
      q_next = (|qf[DIV_WIDTH-1:31]) ? 32'sh7FFF_FFFF : $signed(qf[31:0]);
    end else if ((|qf[DIV_WIDTH-1:32]) || (qf[31] && (|qf[30:0]))) begin
      q_next = 32'sh8000_0000;
    end else begin
      q_next = -$signed(qf[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[DIV_STAGES];
    end
    q <= q_next;
  end

endmodule

// ----- rtl/rlud_reproj.sv -----
// reprojection of a distorted Q7.24 coordinate to pixels:
// (f*d + (c << 24)) >> 28 toward zero, saturated to 16 bits; depends on rlud_pkg
module rlud_reproj import rlud_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] d,
  input  logic [15:0]        focal,
  input  logic [15:0]        center,
  output logic               out_valid,
  output logic signed [15:0] coord
);

  logic               v1;
  logic signed [48:0] prod;
  logic signed [49:0] sum;
  logic signed [49:0] sum_adj;
  logic signed [21:0] shifted;
  logic signed [15:0] coord_next;

  // stage one: focal times coordinate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    prod <= $signed({1'b0, focal}) * d;
  end

  // stage two: add center, shift toward zero, saturate
  always_comb begin
    sum     = 50'(prod) + $signed({10'd0, center, 24'd0});
    sum_adj = sum + ((sum < 0) ? 50'sd268435455 : 50'sd0);
    shifted = 22'(sum_adj >>> 28);
    if (shifted > 22'sd32767) begin
      coord_next = 16'sh7FFF;
    end else if (shifted < -22'sd32768) begin
      coord_next = 16'sh8000;
    end else begin
      coord_next = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    coord <= coord_next;
  end

endmodule
